// ===== sv/wpf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpf_pkg
// Types and arithmetic helpers shared by the waypoint follower block.
// ----------------------------------------------------------------------------
package wpf_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // One waypoint as held in the ring and in the target register
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [15:0] radius;
    } wp_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] wp_x;
        logic signed [15:0] wp_y;
        logic        [15:0] wp_radius;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] desired_x;
        logic signed [15:0] desired_y;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic               has_destination;
        logic               load_rejected;
    } out_item_t;

    // Square of a 17-bit difference; the magnitude never exceeds 65535
    function automatic logic [31:0] sq17(input logic signed [16:0] d);
        logic signed [33:0] p;
        p = d * d;
        return p[31:0];
    endfunction

    // Unit step on one axis: sign(d) when 3*d*d >= e*e, else 0
    function automatic logic signed [1:0] axis_step(input logic signed [16:0] d,
                                                    input logic [31:0] dsq,
                                                    input logic [31:0] esq);
        logic [33:0] three_d;
        three_d = {2'b00, dsq} + {1'b0, dsq, 1'b0};
        if (d == 17'sd0) begin
            return 2'sd0;
        end
        else if (three_d >= {2'b00, esq}) begin
            return d[16] ? -2'sd1 : 2'sd1;
        end
        else begin
            return 2'sd0;
        end
    endfunction

    // Position plus step, clamped to the signed 16-bit range
    function automatic logic signed [15:0] sat_add(input logic signed [15:0] p,
                                                   input logic signed [1:0] s);
        logic signed [16:0] sum;
        sum = 17'(p) + 17'(s);
        if (sum > 17'sd32767) begin
            return 16'sh7fff;
        end
        else if (sum < -17'sd32768) begin
            return 16'sh8000;
        end
        else begin
            return sum[15:0];
        end
    endfunction

endpackage

// ===== sv/wpf_if.sv =====
// ----------------------------------------------------------------------------
// wpf_in_if / wpf_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface wpf_in_if;
    logic              valid;
    logic              ready;
    wpf_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wpf_out_if;
    logic               valid;
    logic               ready;
    wpf_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/waypoint_follow_agent_step.sv =====
// ----------------------------------------------------------------------------
// waypoint_follow_agent_step
// Steers one agent around a ring of waypoints, one result per input item.
// ----------------------------------------------------------------------------
// Usage:
//   req carries input items: kind 0 appends a waypoint to the ring, kind 1
//   is a tick with the agent's current position. rsp carries exactly one
//   result per item, in order. A transfer happens on a clock edge with
//   valid and ready both high.
//   Throughput is one item per cycle while the skid entry is free. Each
//   result is registered and offered on rsp, or held in the skid entry.
//   The ring front is kept pre-read from the ring memory (registered read,
//   addressed by the next head), so a tick finds its next target without
//   waiting; a write to the entry being read is forwarded.
//   A result register plus one skid entry part the two channels: while
//   rsp stalls, one further item is still taken; req.ready drops only when
//   both entries hold results.
//   Reset (rst_n low, asynchronous) empties the ring, clears the target and
//   drops any pending results. No clearing pass is needed: ring entries are
//   only read after they were written.
// ----------------------------------------------------------------------------
module waypoint_follow_agent_step #(
    parameter int MAX_WAYPOINTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wpf_in_if.sink    req,
    wpf_out_if.source rsp
);

    localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
    localparam int SUM_W = CNT_W + 1;

    // State
    logic                    tgt_valid_reg, tgt_valid_next;
    wpf_pkg::wp_t            tgt_reg, tgt_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    wpf_pkg::out_item_t      out_reg, skid_reg;
    logic                    out_valid_reg, skid_valid_reg;

    // Ring interface
    logic                    ring_we;
    logic [IDX_W-1:0]        ring_waddr;
    wpf_pkg::wp_t            ring_wdata;
    wpf_pkg::wp_t            front;

    // Datapath
    logic                    fire_in, fire_out, is_tick, full, empty;
    logic                    reached, take;
    logic [IDX_W-1:0]        head_inc;
    logic [SUM_W-1:0]        slot_sum, slot_wrap;
    logic signed [16:0]      dxo, dyo, dxf, dyf;
    logic [31:0]             sq_dxo, sq_dyo, sq_dxf, sq_dyf, sq_r;
    logic [32:0]             dist_sq;
    logic signed [1:0]       stx_old, sty_old, stx_frt, sty_frt, stx, sty;
    wpf_pkg::out_item_t      res;

    wpf_ring #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .IDX_W         (IDX_W)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_next),
        .front (front)
    );

    assign req.ready = !skid_valid_reg;
    assign fire_in   = req.valid && !skid_valid_reg;
    assign fire_out  = out_valid_reg && rsp.ready;
    assign is_tick   = (req.data.kind == wpf_pkg::KIND_TICK);
    assign full      = (count_reg == CNT_W'(MAX_WAYPOINTS));
    assign empty     = (count_reg == '0);

    // Ring index arithmetic: back slot is (head + count) mod depth
    assign head_inc  = (head_reg == IDX_W'(MAX_WAYPOINTS - 1)) ? '0 : head_reg + 1'b1;
    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign slot_wrap = (slot_sum >= SUM_W'(MAX_WAYPOINTS))
                       ? slot_sum - SUM_W'(MAX_WAYPOINTS) : slot_sum;

    // Distances to the held target and to the ring front, in parallel
    always_comb
    begin
        dxo     = 17'(tgt_reg.x) - 17'(req.data.pos_x);
        dyo     = 17'(tgt_reg.y) - 17'(req.data.pos_y);
        dxf     = 17'(front.x) - 17'(req.data.pos_x);
        dyf     = 17'(front.y) - 17'(req.data.pos_y);
        sq_dxo  = wpf_pkg::sq17(dxo);
        sq_dyo  = wpf_pkg::sq17(dyo);
        sq_dxf  = wpf_pkg::sq17(dxf);
        sq_dyf  = wpf_pkg::sq17(dyf);
        sq_r    = 32'(tgt_reg.radius) * 32'(tgt_reg.radius);
        dist_sq = 33'(sq_dxo) + 33'(sq_dyo);
        stx_old = wpf_pkg::axis_step(dxo, sq_dxo, sq_dyo);
        sty_old = wpf_pkg::axis_step(dyo, sq_dyo, sq_dxo);
        stx_frt = wpf_pkg::axis_step(dxf, sq_dxf, sq_dyf);
        sty_frt = wpf_pkg::axis_step(dyf, sq_dyf, sq_dxf);
    end

    assign reached = tgt_valid_reg && (dist_sq < 33'(sq_r));
    assign take    = is_tick && (reached || !tgt_valid_reg) && !empty;

    // Next state, ring write and result for the item on req
    always_comb
    begin
        tgt_valid_next = tgt_valid_reg;
        tgt_next       = tgt_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ring_we        = 1'b0;
        ring_waddr     = slot_wrap[IDX_W-1:0];
        ring_wdata     = tgt_reg;
        stx            = take ? stx_frt : stx_old;
        sty            = take ? sty_frt : sty_old;
        res            = '0;

        if (is_tick)
        begin
            // Rotate: take the front, push the old target (if any) to the back
            if (take)
            begin
                tgt_next       = front;
                tgt_valid_next = 1'b1;
                head_next      = head_inc;
                if (tgt_valid_reg)
                begin
                    ring_we = 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            if (tgt_valid_next)
            begin
                res.desired_x = wpf_pkg::sat_add(req.data.pos_x, stx);
                res.desired_y = wpf_pkg::sat_add(req.data.pos_y, sty);
            end
            else
            begin
                res.desired_x = req.data.pos_x;
                res.desired_y = req.data.pos_y;
            end
        end
        else
        begin
            // Append, or drop when full
            ring_wdata.x      = req.data.wp_x;
            ring_wdata.y      = req.data.wp_y;
            ring_wdata.radius = req.data.wp_radius;
            if (full)
            begin
                res.load_rejected = 1'b1;
            end
            else
            begin
                ring_we    = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end

        res.has_destination = tgt_valid_next;
        if (tgt_valid_next)
        begin
            res.dest_x = tgt_next.x;
            res.dest_y = tgt_next.y;
        end

        // Hold everything unless an item transfers
        if (!fire_in)
        begin
            tgt_valid_next = tgt_valid_reg;
            tgt_next       = tgt_reg;
            head_next      = head_reg;
            count_next     = count_reg;
            ring_we        = 1'b0;
        end
    end

    // Agent and ring control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_valid_reg <= 1'b0;
            tgt_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            tgt_valid_reg <= tgt_valid_next;
            tgt_reg       <= tgt_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    // Result register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (fire_out)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fire_in)
        begin
            if (out_valid_reg && !rsp.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (fire_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (fire_out)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (fire_in)
        begin
            if (out_valid_reg && !rsp.ready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

// ===== sv/wpf_ring.sv =====
// ----------------------------------------------------------------------------
// wpf_ring
// Waypoint ring storage: one write port, one registered read port that
// tracks the ring front, with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module wpf_ring #(
    parameter int MAX_WAYPOINTS = 16,
    parameter int IDX_W         = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  wpf_pkg::wp_t      wdata,
    input  logic [IDX_W-1:0]  raddr,
    output wpf_pkg::wp_t      front
);

    wpf_pkg::wp_t mem [MAX_WAYPOINTS];
    wpf_pkg::wp_t rdata_reg;
    wpf_pkg::wp_t byp_data_reg;
    logic         byp_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg    <= mem[raddr];
        byp_data_reg <= wdata;
    end

    // Flag a write landing on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= we && (waddr == raddr);
        end
    end

    assign front = byp_reg ? byp_data_reg : rdata_reg;

endmodule
